FILE: design/esd_pkg.sv
// shared types, character codes and status codes for the escape sequence decoder
package esd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [2:0] status;
        logic       string_done;
    } t_out_item;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DANGLING = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_BADHEX   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // {bad, value}: bad is set when the byte is not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = {1'b0, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = {1'b0, 4'(b - 8'h37)};
        end
        return d;
    endfunction

endpackage

FILE: design/esd_core.sv
// escape state machine and result register of the escape sequence decoder
module esd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  esd_pkg::t_in_item  i_item,
    output esd_pkg::t_out_item o_item
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        MODE_LIT,
        MODE_ESC,
        MODE_HEX1,
        MODE_HEX2,
        MODE_SKIP_HEX,
        MODE_SKIP_UNK
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [3:0] r_high_nibble, n_high_nibble;
    logic       r_high_bad, n_high_bad;
    logic       r_any_emitted, n_any_emitted;
    t_out_item  r_res, n_res;

    logic [4:0] w_digit;
    logic [7:0] w_b;
    logic       w_fin;

    assign w_b     = i_item.in_byte;
    assign w_fin   = i_item.final_byte;
    assign w_digit = hex_digit(w_b);

    always_comb begin
        n_mode        = r_mode;
        n_high_nibble = r_high_nibble;
        n_high_bad    = r_high_bad;
        n_any_emitted = r_any_emitted;
        n_res         = '0;
        n_res.status  = ST_OK;
        unique case (r_mode)
            MODE_LIT: begin
                if (w_b == CH_BSLASH) begin
                    if (w_fin) begin
                        n_res.status = ST_DANGLING;
                    end else begin
                        n_mode = MODE_ESC;
                    end
                end else begin
                    n_res.out_byte  = w_b;
                    n_res.out_valid = 1'b1;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_LIT;
                unique case (w_b) inside
                    CH_BSLASH, CH_QUOTE: begin
                        n_res.out_byte  = w_b;
                        n_res.out_valid = 1'b1;
                    end
                    CH_N: begin
                        n_res.out_byte  = CH_LF;
                        n_res.out_valid = 1'b1;
                    end
                    CH_R: begin
                        n_res.out_byte  = CH_CR;
                        n_res.out_valid = 1'b1;
                    end
                    CH_T: begin
                        n_res.out_byte  = CH_TAB;
                        n_res.out_valid = 1'b1;
                    end
                    CH_X: begin
                        if (w_fin) begin
                            n_res.status = ST_TRUNC;
                        end else begin
                            n_mode = MODE_HEX1;
                        end
                    end
                    default: begin
                        n_res.status = ST_UNKNOWN;
                        n_mode       = MODE_SKIP_UNK;
                    end
                endcase
            end
            MODE_HEX1: begin
                if (w_fin) begin
                    n_res.status = ST_TRUNC;
                end else begin
                    n_high_bad    = w_digit[4];
                    n_high_nibble = w_digit[3:0];
                    n_mode        = MODE_HEX2;
                end
            end
            MODE_HEX2: begin
                if (r_high_bad || w_digit[4]) begin
                    n_res.status = ST_BADHEX;
                    n_mode       = MODE_SKIP_HEX;
                end else begin
                    n_res.out_byte  = {r_high_nibble, w_digit[3:0]};
                    n_res.out_valid = 1'b1;
                    n_mode          = MODE_LIT;
                end
                n_high_nibble = '0;
                n_high_bad    = 1'b0;
            end
            MODE_SKIP_HEX: n_res.status = ST_BADHEX;
            MODE_SKIP_UNK: n_res.status = ST_UNKNOWN;
            default:       n_mode = MODE_LIT;
        endcase

        if (n_res.out_valid) begin
            n_any_emitted = 1'b1;
        end

        // last byte: empty status if OK and none emitted; return to reset state
        if (w_fin) begin
            if (n_res.status == ST_OK && !n_any_emitted) begin
                n_res.status = ST_EMPTY;
            end
            n_mode        = MODE_LIT;
            n_high_nibble = '0;
            n_high_bad    = 1'b0;
            n_any_emitted = 1'b0;
        end
        n_res.string_done = w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_LIT;
            r_high_nibble <= '0;
            r_high_bad    <= 1'b0;
            r_any_emitted <= 1'b0;
        end else if (i_en) begin
            r_mode        <= n_mode;
            r_high_nibble <= n_high_nibble;
            r_high_bad    <= n_high_bad;
            r_any_emitted <= n_any_emitted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_item = r_res;

    a_close_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.final_byte |=> r_mode == MODE_LIT && !r_any_emitted && !r_high_bad)
        else $error("string close did not return decoder to literal mode");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_en) && r_res.out_valid |-> r_res.status == ST_OK)
        else $error("decoded byte reported together with an error status");

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (r_mode == MODE_SKIP_HEX || r_mode == MODE_SKIP_UNK) |=> !r_res.out_valid)
        else $error("byte emitted while skipping after an error");

    a_hex_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_bad |-> r_mode == MODE_HEX2)
        else $error("bad high digit flag held outside second hex digit");

endmodule

FILE: design/escape_sequence_decoder_unit.sv
// top level of the escape sequence decoder: input register, decoder core, output handshake
// Decodes C-style escapes in a pattern string streamed one byte per transaction, with
// final_byte marking the last byte. Every input transaction yields exactly one result
// transaction: a decoded byte when out_valid is set, otherwise a status, and string_done
// on the result of the final byte. The unit sustains one byte per clock while the output
// is ready. A byte is held in the input register and then moves into the result register
// of the escape state machine, from which its result is offered on the output.
// Backpressure on the output stalls the input only when both registers are full.
module escape_sequence_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  esd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output esd_pkg::t_out_item o_out_item
);
    import esd_pkg::*;

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    logic     w_adv;

    // input stage moves into the result register when that register is free or being taken
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    esd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in_item),
        .o_item  (o_out_item)
    );

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !w_adv)
        else $error("result register overwritten before transaction completed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_item))
        else $error("stalled input register lost its byte");

    a_fill_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced byte did not reach the output");

endmodule
